// File: rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants of the merge sort engine
// Item structs of both channels plus the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mse_pkg;

   // Fixed element width of the channel payloads
   localparam int DATA_WIDTH = 32;
   // Default buffer depth in elements
   localparam int MAX_ELEMENTS_DEF = 64;

   // Input item
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last_in;
   } req_type;

   // Result item
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         last_out;
      logic                         overflow;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // store the accepted element or flag a drop
      logic sort_init;   // run width 1, first run, source is the load buffer
      logic run_init;    // set up bounds and pointers of the current run pair
      logic merge_step;  // move one element into the destination buffer
      logic run_next;    // advance to the next run pair
      logic pass_next;   // double run width, swap buffers
      logic emit_init;   // rewind the read pointer for output
      logic emit_step;   // advance the output pointer
      logic clear;       // empty the set
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic pass_done;   // run width covers the whole set: sorted
      logic runs_done;   // no run pair left in this pass
      logic run_last;    // current merge step writes the last element of the pair
      logic emit_last;   // current output element is the final one
   } status_type;

endpackage

// File: rtl/mse_datapath.sv
// ----------------------------------------------------------------------------
// mse_datapath: buffers, pointers and merge compare
// Two element buffers used ping-pong, run and pointer registers of the
// bottom-up merge, and the result fields.
// ----------------------------------------------------------------------------
module mse_datapath #(
   parameter int MAX_ELEMENTS = mse_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mse_pkg::cmd_type                    cmd,
   input  logic signed [mse_pkg::DATA_WIDTH-1:0] load_value,
   output mse_pkg::status_type                 status,
   output mse_pkg::rsp_type                    rsp_data
);
   import mse_pkg::*;

   localparam int ADDR_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int WIDE_W = CNT_W + 2;

   // Element buffers: data_mem is loaded, merge_mem is scratch
   logic [DATA_WIDTH-1:0] data_mem_ff  [MAX_ELEMENTS];
   logic [DATA_WIDTH-1:0] merge_mem_ff [MAX_ELEMENTS];
   logic [DATA_WIDTH-1:0] rd_data_a_ff, rd_data_b_ff, rd_merge_a_ff, rd_merge_b_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              drop_ff, drop_in;
   logic [WIDE_W-1:0] width_ff, width_in;
   logic [WIDE_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0]  mid_ff, mid_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  a_ff, a_in;
   logic [CNT_W-1:0]  b_ff, b_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic              src_ff, src_in;   // 0: data_mem is source

   logic [WIDE_W-1:0] n_wide, lo_plus_w, lo_plus_2w;
   logic signed [DATA_WIDTH-1:0] head_a, head_b, chosen;
   logic              a_valid, b_valid, take_a, room;
   logic              wr_data_en, wr_merge_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_WIDTH-1:0] wr_value;

   // Run heads from the source buffer
   assign head_a  = src_ff ? $signed(rd_merge_a_ff) : $signed(rd_data_a_ff);
   assign head_b  = src_ff ? $signed(rd_merge_b_ff) : $signed(rd_data_b_ff);
   assign a_valid = a_ff < mid_ff;
   assign b_valid = b_ff < hi_ff;
   // Left run wins ties
   assign take_a  = a_valid && (!b_valid || (head_a <= head_b));
   assign chosen  = take_a ? head_a : head_b;

   assign n_wide     = WIDE_W'(count_ff);
   assign lo_plus_w  = lo_ff + width_ff;
   assign lo_plus_2w = lo_ff + (width_ff << 1);
   assign room       = count_ff < CNT_W'(MAX_ELEMENTS);

   // Buffer write port selection
   assign wr_data_en  = (cmd.load && room) || (cmd.merge_step && src_ff);
   assign wr_merge_en = cmd.merge_step && !src_ff;
   assign wr_addr     = cmd.load ? count_ff[ADDR_W-1:0] : k_ff[ADDR_W-1:0];
   assign wr_value    = cmd.load ? load_value : chosen;

   // Next-value logic of pointers and counters
   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      width_in = width_ff;
      lo_in    = lo_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      src_in   = src_ff;
      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end
      if (cmd.sort_init) begin
         width_in = WIDE_W'(1);
         lo_in    = '0;
         src_in   = 1'b0;
      end
      if (cmd.run_init) begin
         mid_in = (lo_plus_w  > n_wide) ? count_ff : lo_plus_w[CNT_W-1:0];
         hi_in  = (lo_plus_2w > n_wide) ? count_ff : lo_plus_2w[CNT_W-1:0];
         a_in   = lo_ff[CNT_W-1:0];
         b_in   = (lo_plus_w  > n_wide) ? count_ff : lo_plus_w[CNT_W-1:0];
         k_in   = lo_ff[CNT_W-1:0];
      end
      if (cmd.merge_step) begin
         k_in = k_ff + 1'b1;
         if (take_a) begin
            a_in = a_ff + 1'b1;
         end else begin
            b_in = b_ff + 1'b1;
         end
      end
      if (cmd.run_next) begin
         lo_in = lo_plus_2w;
      end
      if (cmd.pass_next) begin
         width_in = width_ff << 1;
         lo_in    = '0;
         src_in   = !src_ff;
      end
      if (cmd.emit_init) begin
         a_in = '0;
      end
      if (cmd.emit_step) begin
         a_in = a_ff + 1'b1;
      end
      if (cmd.clear) begin
         count_in = '0;
         drop_in  = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   // Run and pointer registers
   always_ff @(posedge clock) begin
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
      src_ff   <= src_in;
   end

   // Buffers: one write, two registered reads each
   always_ff @(posedge clock) begin
      if (wr_data_en) begin
         data_mem_ff[wr_addr] <= wr_value;
      end
      if (wr_merge_en) begin
         merge_mem_ff[wr_addr] <= wr_value;
      end
      rd_data_a_ff  <= data_mem_ff[a_ff[ADDR_W-1:0]];
      rd_data_b_ff  <= data_mem_ff[b_ff[ADDR_W-1:0]];
      rd_merge_a_ff <= merge_mem_ff[a_ff[ADDR_W-1:0]];
      rd_merge_b_ff <= merge_mem_ff[b_ff[ADDR_W-1:0]];
   end

   // Status toward the controller
   assign status.pass_done = width_ff >= n_wide;
   assign status.runs_done = lo_ff >= n_wide;
   assign status.run_last  = ({1'b0, k_ff} + 1'b1) == {1'b0, hi_ff};
   assign status.emit_last = ({1'b0, a_ff} + 1'b1) == {1'b0, count_ff};

   // Result fields
   assign rsp_data.sorted_value = head_a;
   assign rsp_data.last_out     = status.emit_last;
   assign rsp_data.overflow     = drop_ff;

endmodule

// File: rtl/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl: sequencer of the merge sort engine
// One-hot state machine that loads the set, walks the merge passes and
// run pairs, and then streams out the sorted set.
// ----------------------------------------------------------------------------
module mse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                last_in,
   input  mse_pkg::status_type status,
   output mse_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_strobe
);
   import mse_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE       = 11'b000_0000_0001,
      ST_SORT_START = 11'b000_0000_0010,
      ST_PASS_CHECK = 11'b000_0000_0100,
      ST_RUN_INIT   = 11'b000_0000_1000,
      ST_MERGE_RD   = 11'b000_0001_0000,
      ST_MERGE_WR   = 11'b000_0010_0000,
      ST_RUN_NEXT   = 11'b000_0100_0000,
      ST_RUN_CHECK  = 11'b000_1000_0000,
      ST_EMIT_START = 11'b001_0000_0000,
      ST_EMIT_RD    = 11'b010_0000_0000,
      ST_EMIT_OUT   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (last_in) begin
                  state_in = ST_SORT_START;
               end
            end
         end
         ST_SORT_START: begin
            cmd.sort_init = 1'b1;
            state_in      = ST_PASS_CHECK;
         end
         ST_PASS_CHECK: begin
            state_in = status.pass_done ? ST_EMIT_START : ST_RUN_INIT;
         end
         ST_RUN_INIT: begin
            cmd.run_init = 1'b1;
            state_in     = ST_MERGE_RD;
         end
         ST_MERGE_RD: begin
            // registered reads of both run heads are captured in this state for ST_MERGE_WR
            state_in = ST_MERGE_WR;
         end
         ST_MERGE_WR: begin
            cmd.merge_step = 1'b1;
            state_in       = status.run_last ? ST_RUN_NEXT : ST_MERGE_RD;
         end
         ST_RUN_NEXT: begin
            cmd.run_next = 1'b1;
            state_in     = ST_RUN_CHECK;
         end
         ST_RUN_CHECK: begin
            if (status.runs_done) begin
               cmd.pass_next = 1'b1;
               state_in      = ST_PASS_CHECK;
            end else begin
               state_in = ST_RUN_INIT;
            end
         end
         ST_EMIT_START: begin
            cmd.emit_init = 1'b1;
            state_in      = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            cmd.emit_step = 1'b1;
            if (status.emit_last) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = state_ff == ST_EMIT_OUT;

endmodule

// File: rtl/merge_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// merge_sort_engine_unit: stable ascending sort of a set of signed values
// Buffers a set of elements, sorts it bottom-up by merging runs between two
// buffers, and streams out the sorted set.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item is taken at a clock edge with start high and busy low,
//   one element per cycle while loading. req_data.last_in closes the set.
//   Elements beyond MAX_ELEMENTS are dropped and overflow is reported on
//   every result of that set; a dropped element with last_in still closes it.
//   Output: each sorted element appears for one cycle with rsp_strobe high;
//   the final one carries last_out. The receiver cannot stall the block.
//   Timing: from the item with last_in, the sort runs P = ceil(log2 n)
//   merge passes over the n elements, with the run pairs of each pass in
//   turn; each merged element takes a buffer read state and a
//   compare-and-write state, and each output takes a read state and an
//   output state.
//   busy stays high from the closing item until the last result.
//   Reset empties the set and returns to loading; buffer contents are not
//   cleared and need not be.
// ----------------------------------------------------------------------------
module merge_sort_engine_unit #(
   parameter int MAX_ELEMENTS = mse_pkg::MAX_ELEMENTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mse_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mse_pkg::rsp_type rsp_data
);
   import mse_pkg::*;

   cmd_type    cmd;
   status_type status;

   mse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_in    (req_data.last_in),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   mse_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .load_value (req_data.value),
      .status     (status),
      .rsp_data   (rsp_data)
   );

   // Results only come out while a set is being processed
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // The final result returns the block to loading
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_out) |=> !busy)
      else $error("block still busy after final result");

   // Sorting starts only from an accepted closing item
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_data.last_in))
      else $error("busy raised without a closing item");

   // A closing item always starts the sort
   a_close_sorts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last_in) |=> busy)
      else $error("closing item did not start the sort");

endmodule

// File: test/merge_sort_checker.sv
// ----------------------------------------------------------------------------
// merge_sort_checker: prediction and compare for the merge sort engine
// Watches accepted input items, keeps its own copy of the element buffer,
// sorts each closed set with a stable bottom-up merge and checks every
// result strobe against the oldest predicted element, field by field.
// ----------------------------------------------------------------------------
module merge_sort_checker #(
   parameter int MAX_ELEMENTS = mse_pkg::MAX_ELEMENTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  mse_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  mse_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_results,
   output int               results_checked
);

   // Shadow of the block's set buffer
   logic signed [mse_pkg::DATA_WIDTH-1:0] element_buf [MAX_ELEMENTS];
   int                                    stored_count;
   logic                                  drop_seen;

   // Sorted elements still to come out of the block, oldest first
   mse_pkg::rsp_type expected_sorted [$];

   // Bottom-up merge of the buffered set, left run wins ties
   task automatic queue_sorted_set(input int n);
      logic signed [mse_pkg::DATA_WIDTH-1:0] src [MAX_ELEMENTS];
      logic signed [mse_pkg::DATA_WIDTH-1:0] dst [MAX_ELEMENTS];
      int               width;
      int               lo;
      int               mid;
      int               hi;
      int               a;
      int               b;
      int               k;
      mse_pkg::rsp_type entry;
      src = element_buf;
      dst = element_buf;
      for (width = 1; width < n; width = width * 2) begin
         for (lo = 0; lo < n; lo = lo + 2 * width) begin
            mid = (lo + width < n) ? lo + width : n;
            hi  = (lo + 2 * width < n) ? lo + 2 * width : n;
            a   = lo;
            b   = mid;
            for (k = lo; k < hi; k++) begin
               if (a < mid && (b >= hi || src[a] <= src[b])) begin
                  dst[k] = src[a];
                  a++;
               end else begin
                  dst[k] = src[b];
                  b++;
               end
            end
         end
         src = dst;
      end
      for (k = 0; k < n; k++) begin
         entry.sorted_value = src[k];
         entry.last_out     = (k == n - 1);
         entry.overflow     = drop_seen;
         expected_sorted.push_back(entry);
      end
   endtask

   // Compare results first, then fold in the accepted item
   always @(posedge clock) begin : monitor
      mse_pkg::rsp_type want;
      int               errs;
      errs = 0;
      if (reset) begin
         stored_count = 0;
         drop_seen    = 1'b0;
         expected_sorted.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_sorted.size() == 0) begin
               $error("unexpected result: sorted_value %0d with nothing pending",
                      rsp_data.sorted_value);
               errs++;
            end else begin
               want = expected_sorted.pop_front();
               if (rsp_data.sorted_value !== want.sorted_value) begin
                  $error("sorted_value: expected %0d, got %0d",
                         want.sorted_value, rsp_data.sorted_value);
                  errs++;
               end
               if (rsp_data.last_out !== want.last_out) begin
                  $error("last_out: expected %0b, got %0b", want.last_out, rsp_data.last_out);
                  errs++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_data.overflow);
                  errs++;
               end
               results_checked <= results_checked + 1;
            end
         end
         if (start && !busy) begin
            // full buffer drops the element but a last_in still closes the set
            if (stored_count < MAX_ELEMENTS) begin
               element_buf[stored_count] = req_data.value;
               stored_count++;
            end else begin
               drop_seen = 1'b1;
            end
            if (req_data.last_in) begin
               queue_sorted_set(stored_count);
               stored_count = 0;
               drop_seen    = 1'b0;
            end
         end
      end
      mismatch_count  <= mismatch_count + errs;
      pending_results <= expected_sorted.size();
   end

endmodule

// File: test/tb_merge_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_merge_sort_engine_unit: regression for the merge sort engine
// Drives directed sets (extremes, duplicates, reverse order) and then random
// sets of mixed sizes, including a full buffer and a set that overflows with
// last_in on a dropped item. Input idles in random bursts; checking is done
// by merge_sort_checker beside the block.
// ----------------------------------------------------------------------------
module tb_merge_sort_engine_unit;

   localparam int MAX_ELEMENTS   = mse_pkg::MAX_ELEMENTS_DEF;
   localparam int RANDOM_ITEMS   = 280;
   localparam int QUIET_AFTER    = 230;   // random items before idling stops
   localparam int WATCHDOG_LIMIT = 6000;  // limit on cycles without a handshake
   localparam int TAIL_CYCLES    = 20;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   logic             busy;
   mse_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   mse_pkg::rsp_type rsp_data;

   int mismatch_count;
   int pending_results;
   int results_checked;
   int items_sent;
   int random_items;
   int sets_sent;
   int overflow_sets;
   int stall_count;
   bit idling_on;

   logic signed [mse_pkg::DATA_WIDTH-1:0] directed_set [$];

   merge_sort_engine_unit #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   merge_sort_checker #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_data        (rsp_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   always #1 clock = ~clock;

   // Watchdog: no item in or out for too long ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", stall_count);
            $display("merge_sort_engine_unit regression: fail");
            $finish;
         end
      end
   end

   // Element values biased toward the extremes and toward duplicates
   function automatic logic signed [mse_pkg::DATA_WIDTH-1:0] draw_element();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return int'($urandom_range(0, 8)) - 4;
         3: return 32'sh8000_0000 + $urandom_range(0, 3);
         4: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // One item; holds start until taken, then maybe idles a short burst
   task automatic send_element(input logic signed [mse_pkg::DATA_WIDTH-1:0] value,
                               input logic last);
      int gap;
      start            = 1'b1;
      req_data.value   = value;
      req_data.last_in = last;
      do @(posedge clock); while (busy);
      items_sent++;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap      = $urandom_range(1, 5);
         start    = 1'b0;
         req_data = mse_pkg::req_type'({$urandom, 1'($urandom)});
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_list(input logic signed [mse_pkg::DATA_WIDTH-1:0] vals [$]);
      for (int i = 0; i < vals.size(); i++) begin
         send_element(vals[i], i == vals.size() - 1);
      end
      sets_sent++;
   endtask

   // Stimulus
   initial begin
      int set_size;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset     = 1'b0;
      idling_on = 1'b1;

      // single element at the top of the range
      directed_set = '{32'sh7FFF_FFFF};
      send_list(directed_set);
      // both extremes, zero, minus one and alternating bit patterns
      directed_set = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
                       32'sh0000_0001, 32'sh8000_0000, 32'shFFFF_FFFF, 32'sh5555_5555,
                       32'shAAAA_AAAA};
      send_list(directed_set);
      // reverse order with duplicate pairs
      directed_set = '{32'sd7, 32'sd7, 32'sd3, 32'sd3, -32'sd2, -32'sd2, -32'sd9};
      send_list(directed_set);
      // already in order
      directed_set = '{-32'sd5, 32'sd10};
      send_list(directed_set);

      // Random sets: a full buffer, an overflowing set, then mostly small ones
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (sets_sent == 4) begin
            set_size = MAX_ELEMENTS;
         end else if (sets_sent == 5) begin
            set_size = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 6);
         end else if ($urandom_range(0, 9) == 0) begin
            set_size = $urandom_range(17, 48);
         end else begin
            set_size = $urandom_range(1, 16);
         end
         if (set_size > MAX_ELEMENTS) begin
            overflow_sets++;
         end
         for (int i = 0; i < set_size; i++) begin
            idling_on = (random_items < QUIET_AFTER);
            send_element(draw_element(), i == set_size - 1);
            random_items++;
         end
         sets_sent++;
      end

      // Drain
      start = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d sets from %0d items, %0d of them overflowing the buffer",
               sets_sent, items_sent, overflow_sets);
      $display("checked %0d sorted results, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("merge_sort_engine_unit regression: pass");
      end else begin
         $display("merge_sort_engine_unit regression: fail");
      end
      $finish;
   end

endmodule
